[rtl/ibop_pkg.sv]
// Package for the interval buffer offset planner.
// Holds the opcode and state encodings and the default sizes.
// No dependencies.
`default_nettype none
package ibop_pkg;

    localparam int VAL_W           = 40;
    localparam int IDX_IN_W        = 8;
    localparam int MAX_BUFFERS_DEF = 256;
    localparam int STEP_BITS_DEF   = 10;
    localparam int SIZE_BITS_DEF   = 32;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_PLAN  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_DELIVER,
        ST_S_RI,
        ST_S_RI_W,
        ST_S_SCAN,
        ST_S_SWR,
        ST_P_RS,
        ST_P_RS_W,
        ST_P_RT,
        ST_P_EXP,
        ST_P_EXP_A,
        ST_P_EXP_T,
        ST_P_EXP_M,
        ST_P_FREE,
        ST_P_FREE_W,
        ST_P_FREE_M,
        ST_P_BUMP,
        ST_P_PLACE,
        ST_P_NEXT,
        ST_P_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/ibop_req_if.sv]
// Request channel of the planner: opcode and buffer description.
// Depends on ibop_pkg.
`default_nettype none
interface ibop_req_if #(
    parameter int STEP_BITS = ibop_pkg::STEP_BITS_DEF,
    parameter int SIZE_BITS = ibop_pkg::SIZE_BITS_DEF
);
    import ibop_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [IDX_IN_W-1:0]  buffer_index;
    logic [STEP_BITS-1:0] first_step;
    logic [STEP_BITS-1:0] last_step;
    logic [SIZE_BITS-1:0] byte_size;

    modport source (output valid, operation, buffer_index, first_step, last_step,
                    byte_size, input ready);
    modport sink   (input valid, operation, buffer_index, first_step, last_step,
                    byte_size, output ready);
endinterface
`default_nettype wire

[rtl/ibop_rsp_if.sv]
// Response channel of the planner: arena size or buffer offset.
// Depends on ibop_pkg.
`default_nettype none
interface ibop_rsp_if;
    import ibop_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             placed;

    modport source (output valid, value, placed, input ready);
    modport sink   (input valid, value, placed, output ready);
endinterface
`default_nettype wire

[rtl/ibop_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ibop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/interval_buffer_offset_planner.sv]
// Interval buffer offset planner: linear-scan first-fit arena allocation.
// Clear and load finish on acceptance and return no response; a read passes through
// RD_WAIT and DELIVER before its result is presented. Plan runs a stable rank sort
// (one table read per cycle in the scan), then per buffer scans the active and free lists.
// One item at a time; ready is high only between items. Reset clears counts and
// placed flags; the RAMs are not cleared and need no clearing pass.
`default_nettype none
module interval_buffer_offset_planner #(
    parameter int MAX_BUFFERS = ibop_pkg::MAX_BUFFERS_DEF,
    parameter int STEP_BITS   = ibop_pkg::STEP_BITS_DEF,
    parameter int SIZE_BITS   = ibop_pkg::SIZE_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    ibop_req_if.sink   req,
    ibop_rsp_if.source rsp
);
    import ibop_pkg::*;

    localparam int IDX_W = $clog2(MAX_BUFFERS);
    localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
    localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
    localparam int TBL_W = 2 * STEP_BITS + SIZE_BITS;
    localparam int FRE_W = VAL_W + SIZE_BITS;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     rank_reg, rank_next;
    logic [CNT_W-1:0]     ac_reg, ac_next;
    logic [CNT_W-1:0]     fc_reg, fc_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [STEP_BITS-1:0] start_reg, start_next;
    logic [SIZE_BITS-1:0] need_reg, need_next;
    logic [VAL_W-1:0]     off_reg, off_next;
    logic [VAL_W-1:0]     arena_reg, arena_next;
    logic                 hit_reg, hit_next;
    logic [VAL_W-1:0]     res_value_reg, res_value_next;
    logic                 res_placed_reg, res_placed_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     out_value_reg, out_value_next;
    logic                 out_placed_reg, out_placed_next;
    logic [MAX_BUFFERS-1:0] placed_reg, placed_next;

    logic accept;
    logic last_i, last_j, expire, fit, less;
    logic [IDX_W-1:0] rd_idx;

    // RAM ports
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
    logic [TBL_W-1:0] tbl_wdata, tbl_rdata;
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic             act_we;
    logic [IDX_W-1:0] act_waddr, act_raddr, act_wdata, act_rdata;
    logic             off_we;
    logic [IDX_W-1:0] off_waddr, off_raddr;
    logic [VAL_W-1:0] off_wdata, off_rdata;
    logic             fre_we;
    logic [IDX_W-1:0] fre_waddr, fre_raddr;
    logic [FRE_W-1:0] fre_wdata, fre_rdata;

    logic [STEP_BITS-1:0] tbl_start, tbl_end;
    logic [SIZE_BITS-1:0] tbl_size, fre_size;
    logic [VAL_W-1:0]     fre_off;

    assign tbl_start = tbl_rdata[TBL_W-1 -: STEP_BITS];
    assign tbl_end   = tbl_rdata[SIZE_BITS+STEP_BITS-1 -: STEP_BITS];
    assign tbl_size  = tbl_rdata[SIZE_BITS-1:0];
    assign fre_off   = fre_rdata[FRE_W-1 -: VAL_W];
    assign fre_size  = fre_rdata[SIZE_BITS-1:0];

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.placed = out_placed_reg;

    assign rd_idx = IDX_W'(req.buffer_index);
    assign last_i = (i_reg == count_reg - CNT_W'(1));
    assign last_j = (j_reg == count_reg - CNT_W'(1));
    assign expire = (tbl_end < start_reg);
    assign fit    = (fre_size >= need_reg);
    // stable order: earlier start, or same start and earlier load
    assign less   = (tbl_start < start_reg) || ((tbl_start == start_reg) && (j_reg < i_reg));

    ibop_ram #(.WIDTH(TBL_W), .DEPTH(MAX_BUFFERS)) u_tbl_ram (
        .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr(tbl_raddr), .rdata(tbl_rdata));
    ibop_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUFFERS)) u_ord_ram (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata));
    ibop_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUFFERS)) u_act_ram (
        .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .raddr(act_raddr), .rdata(act_rdata));
    ibop_ram #(.WIDTH(VAL_W), .DEPTH(MAX_BUFFERS)) u_off_ram (
        .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
        .raddr(off_raddr), .rdata(off_rdata));
    ibop_ram #(.WIDTH(FRE_W), .DEPTH(MAX_BUFFERS)) u_fre_ram (
        .clk(clk), .we(fre_we), .waddr(fre_waddr), .wdata(fre_wdata),
        .raddr(fre_raddr), .rdata(fre_rdata));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        OP_PLAN:  state_next = (count_reg == '0) ? ST_P_DONE : ST_S_RI;
                        OP_READ:  state_next = ST_RD_WAIT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_WAIT:  state_next = ST_DELIVER;
            ST_DELIVER:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_S_RI:     state_next = ST_S_RI_W;
            ST_S_RI_W:   state_next = ST_S_SCAN;
            ST_S_SCAN:   state_next = last_j ? ST_S_SWR : ST_S_SCAN;
            ST_S_SWR:    state_next = last_i ? ST_P_RS : ST_S_RI;
            ST_P_RS:     state_next = ST_P_RS_W;
            ST_P_RS_W:   state_next = ST_P_RT;
            ST_P_RT:     state_next = (tbl_size == '0) ? ST_P_NEXT : ST_P_EXP;
            ST_P_EXP:    state_next = (j_reg == ac_reg) ? ST_P_FREE : ST_P_EXP_A;
            ST_P_EXP_A:  state_next = ST_P_EXP_T;
            ST_P_EXP_T:  state_next = expire ? ST_P_EXP_M : ST_P_EXP;
            ST_P_EXP_M:  state_next = ST_P_EXP;
            ST_P_FREE:   state_next = (j_reg == fc_reg) ? ST_P_BUMP : ST_P_FREE_W;
            ST_P_FREE_W: state_next = fit ? ST_P_FREE_M : ST_P_FREE;
            ST_P_FREE_M: state_next = ST_P_PLACE;
            ST_P_BUMP:   state_next = ST_P_PLACE;
            ST_P_PLACE:  state_next = ST_P_NEXT;
            ST_P_NEXT:   state_next = last_i ? ST_P_DONE : ST_P_RS;
            ST_P_DONE:   state_next = ST_DELIVER;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        rank_next       = rank_reg;
        ac_next         = ac_reg;
        fc_next         = fc_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        arena_next      = arena_reg;
        hit_next        = hit_reg;
        res_value_next  = res_value_reg;
        res_placed_next = res_placed_reg;
        placed_next     = placed_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_placed_next = out_placed_reg;

        tbl_we = 1'b0; tbl_waddr = count_reg[IDX_W-1:0];
        tbl_wdata = {req.first_step, req.last_step, req.byte_size};
        tbl_raddr = i_reg[IDX_W-1:0];
        ord_we = 1'b0; ord_waddr = rank_reg[IDX_W-1:0];
        ord_wdata = i_reg[IDX_W-1:0]; ord_raddr = i_reg[IDX_W-1:0];
        act_we = 1'b0; act_waddr = j_reg[IDX_W-1:0]; act_wdata = act_rdata;
        act_raddr = j_reg[IDX_W-1:0];
        off_we = 1'b0; off_waddr = cur_reg; off_wdata = off_reg; off_raddr = rd_idx;
        fre_we = 1'b0; fre_waddr = fc_reg[IDX_W-1:0];
        fre_wdata = {off_rdata, tbl_size}; fre_raddr = j_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        OP_CLEAR: count_next = '0;
                        OP_LOAD:
                        begin
                            if (count_reg != CNT_W'(MAX_BUFFERS))
                            begin
                                tbl_we = 1'b1;
                                placed_next[count_reg[IDX_W-1:0]] = 1'b0;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PLAN:
                        begin
                            i_next      = '0;
                            ac_next     = '0;
                            fc_next     = '0;
                            arena_next  = '0;
                            placed_next = '0;
                        end
                        default:
                        begin
                            hit_next = (CMP_W'(req.buffer_index) < CMP_W'(count_reg))
                                       && placed_reg[rd_idx];
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                res_value_next  = hit_reg ? off_rdata : '0;
                res_placed_next = hit_reg;
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_placed_next = res_placed_reg;
                end
            end
            ST_S_RI: tbl_raddr = i_reg[IDX_W-1:0];
            ST_S_RI_W:
            begin
                start_next = tbl_start;
                j_next     = '0;
                rank_next  = '0;
                tbl_raddr  = '0;
            end
            ST_S_SCAN:
            begin
                rank_next = rank_reg + CNT_W'(less);
                j_next    = j_reg + CNT_W'(1);
                tbl_raddr = IDX_W'(j_reg + CNT_W'(1));
            end
            ST_S_SWR:
            begin
                ord_we = 1'b1;
                i_next = last_i ? '0 : i_reg + CNT_W'(1);
            end
            ST_P_RS: ord_raddr = i_reg[IDX_W-1:0];
            ST_P_RS_W:
            begin
                cur_next  = ord_rdata;
                tbl_raddr = ord_rdata;
            end
            ST_P_RT:
            begin
                start_next = tbl_start;
                need_next  = tbl_size;
                j_next     = '0;
            end
            ST_P_EXP:
            begin
                if (j_reg == ac_reg)
                begin
                    j_next = '0;
                end
            end
            ST_P_EXP_A:
            begin
                tbl_raddr = act_rdata;
                off_raddr = act_rdata;
            end
            ST_P_EXP_T:
            begin
                if (expire)
                begin
                    fre_we    = 1'b1;
                    fc_next   = fc_reg + CNT_W'(1);
                    act_raddr = IDX_W'(ac_reg - CNT_W'(1));
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_P_EXP_M:
            begin
                // swap-remove: last active entry moves into the expired slot
                act_we  = 1'b1;
                ac_next = ac_reg - CNT_W'(1);
            end
            ST_P_FREE: fre_raddr = j_reg[IDX_W-1:0];
            ST_P_FREE_W:
            begin
                if (fit)
                begin
                    off_next  = fre_off;
                    fre_raddr = IDX_W'(fc_reg - CNT_W'(1));
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_P_FREE_M:
            begin
                fre_we    = 1'b1;
                fre_waddr = j_reg[IDX_W-1:0];
                fre_wdata = fre_rdata;
                fc_next   = fc_reg - CNT_W'(1);
            end
            ST_P_BUMP:
            begin
                off_next   = arena_reg;
                arena_next = arena_reg + VAL_W'(need_reg);
            end
            ST_P_PLACE:
            begin
                off_we   = 1'b1;
                placed_next[cur_reg] = 1'b1;
                act_we    = 1'b1;
                act_waddr = ac_reg[IDX_W-1:0];
                act_wdata = cur_reg;
                ac_next   = ac_reg + CNT_W'(1);
            end
            ST_P_NEXT: i_next = i_reg + CNT_W'(1);
            ST_P_DONE:
            begin
                res_value_next  = arena_reg;
                res_placed_next = 1'b0;
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ac_reg        <= '0;
            fc_reg        <= '0;
            arena_reg     <= '0;
            placed_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ac_reg        <= ac_next;
            fc_reg        <= fc_next;
            arena_reg     <= arena_next;
            placed_reg    <= placed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        rank_reg       <= rank_next;
        cur_reg        <= cur_next;
        start_reg      <= start_next;
        need_reg       <= need_next;
        off_reg        <= off_next;
        hit_reg        <= hit_next;
        res_value_reg  <= res_value_next;
        res_placed_reg <= res_placed_next;
        out_value_reg  <= out_value_next;
        out_placed_reg <= out_placed_next;
    end

    // active plus free entries never exceed the buffer count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_NEXT) |->
        ({1'b0, ac_reg} + {1'b0, fc_reg} <= {1'b0, count_reg}))
        else $error("active plus free entries exceed buffer count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_PLACE) |-> (ac_reg < CNT_W'(MAX_BUFFERS)))
        else $error("active list overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_FREE_M) |-> (fc_reg != '0))
        else $error("free list removal while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_EXP_M) |-> (ac_reg != '0 && $past(state_reg) == ST_P_EXP_T))
        else $error("active removal out of sequence");

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking bench for interval_buffer_offset_planner: random loads, plans and reads.
// Built-in first-fit arena planner predicts each plan size and read offset.
// Depends on ibop_pkg, ibop_req_if, ibop_rsp_if and the planner RTL.
`timescale 1ns / 1ps
module testbench;
    import ibop_pkg::*;

    localparam int NBUF      = MAX_BUFFERS_DEF;
    localparam int IDLE_LIMIT = 2000000;

    typedef struct {
        op_t        op;
        logic [7:0] idx;
        logic [9:0] fs;
        logic [9:0] ls;
        logic [31:0] sz;
        bit         sync;
    } req_item_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             placed;
    } answer_t;

    logic clk;
    logic rst_n;

    ibop_req_if req_ch ();
    ibop_rsp_if rsp_ch ();

    interval_buffer_offset_planner DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // planner shadow state
    int unsigned      tbl_count;
    logic [9:0]       tbl_first [NBUF];
    logic [9:0]       tbl_last [NBUF];
    logic [31:0]      tbl_size [NBUF];
    logic [VAL_W-1:0] tbl_offset [NBUF];
    bit               tbl_placed [NBUF];
    logic [VAL_W-1:0] heap_top;

    req_item_t pending_q[$];
    answer_t   answer_q[$];
    int        errors;
    int        beats_in;
    bit        req_taken;
    int        gap_cnt;
    int        hold_cnt;
    bit        long_hold_due;
    int        idle_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Stable first-fit linear scan, mirrors the block's plan action.
    function automatic void plan_arena();
        int          order [NBUF];
        int          live [$];
        logic [VAL_W-1:0] hole_off [$];
        logic [31:0] hole_sz [$];
        int          j;
        int          cur;
        bit          found;
        heap_top = '0;
        for (int i = 0; i < tbl_count; i++)
            tbl_placed[i] = 0;
        for (int i = 0; i < tbl_count; i++)
        begin
            j = i;
            while (j > 0 && tbl_first[order[j-1]] > tbl_first[i])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < tbl_count; i++)
        begin
            cur = order[i];
            if (tbl_size[cur] == 0)
                continue;
            j = 0;
            while (j < live.size())
            begin
                if (tbl_last[live[j]] < tbl_first[cur] && hole_off.size() < NBUF)
                begin
                    hole_off.push_back(tbl_offset[live[j]]);
                    hole_sz.push_back(tbl_size[live[j]]);
                    live[j] = live[live.size()-1];
                    void'(live.pop_back());
                end
                else
                    j++;
            end
            found = 0;
            for (int k = 0; k < hole_off.size(); k++)
            begin
                if (hole_sz[k] >= tbl_size[cur])
                begin
                    tbl_offset[cur] = hole_off[k];
                    hole_off[k] = hole_off[hole_off.size()-1];
                    hole_sz[k] = hole_sz[hole_sz.size()-1];
                    void'(hole_off.pop_back());
                    void'(hole_sz.pop_back());
                    found = 1;
                    break;
                end
            end
            if (!found)
            begin
                tbl_offset[cur] = heap_top;
                heap_top = heap_top + tbl_size[cur];
            end
            tbl_placed[cur] = 1;
            if (live.size() < NBUF)
                live.push_back(cur);
        end
    endfunction

    function automatic void predict_beat(req_item_t it);
        answer_t a;
        case (it.op)
            OP_CLEAR: tbl_count = 0;
            OP_LOAD:
            begin
                if (tbl_count < NBUF)
                begin
                    tbl_first[tbl_count] = it.fs;
                    tbl_last[tbl_count] = it.ls;
                    tbl_size[tbl_count] = it.sz;
                    tbl_placed[tbl_count] = 0;
                    tbl_count++;
                end
            end
            OP_PLAN:
            begin
                plan_arena();
                a.value = heap_top;
                a.placed = 0;
                answer_q.push_back(a);
            end
            default:
            begin
                if (it.idx < tbl_count && tbl_placed[it.idx])
                begin
                    a.value = tbl_offset[it.idx];
                    a.placed = 1;
                end
                else
                begin
                    a.value = '0;
                    a.placed = 0;
                end
                answer_q.push_back(a);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void push_cmd(op_t op, logic [7:0] idx);
        req_item_t it;
        it = '{op: op, idx: idx, fs: '0, ls: '0, sz: '0, sync: 0};
        pending_q.push_back(it);
    endfunction

    function automatic void push_load(logic [9:0] fs, logic [9:0] ls, logic [31:0] sz);
        req_item_t it;
        it = '{op: OP_LOAD, idx: 8'($urandom), fs: fs, ls: ls, sz: sz, sync: 0};
        pending_q.push_back(it);
    endfunction

    function automatic void push_sync();
        req_item_t it;
        it = '{op: OP_CLEAR, idx: '0, fs: '0, ls: '0, sz: '0, sync: 1};
        pending_q.push_back(it);
    endfunction

    // monitor: prediction on request beats, checking on response beats
    always @(posedge clk)
    begin
        answer_t want;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                req_item_t it;
                it = '{op: req_ch.operation, idx: req_ch.buffer_index,
                       fs: req_ch.first_step, ls: req_ch.last_step,
                       sz: req_ch.byte_size, sync: 0};
                predict_beat(it);
                beats_in++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h placed=%b",
                             $time, rsp_ch.value, rsp_ch.placed);
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp_ch.value !== want.value)
                    begin
                        $display("%0t: value expected %h actual %h",
                                 $time, want.value, rsp_ch.value);
                        errors++;
                    end
                    if (rsp_ch.placed !== want.placed)
                    begin
                        $display("%0t: placed expected %b actual %b",
                                 $time, want.placed, rsp_ch.placed);
                        errors++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        req_item_t it;
        if (rst_n && !(req_ch.valid && !req_taken))
        begin
            if (pending_q.size() > 0 && pending_q[0].sync)
            begin
                if (answer_q.size() == 0)
                    void'(pending_q.pop_front());
                req_ch.valid <= 1'b0;
            end
            else if (gap_cnt > 0 || pending_q.size() == 0)
            begin
                if (gap_cnt > 0)
                    gap_cnt = gap_cnt - 1;
                req_ch.valid <= 1'b0;
            end
            else
            begin
                it = pending_q.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.operation    <= it.op;
                req_ch.buffer_index <= it.idx;
                req_ch.first_step   <= it.fs;
                req_ch.last_step    <= it.ls;
                req_ch.byte_size    <= it.sz;
                gap_cnt = pick_gap();
            end
        end
    end

    // response backpressure, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (long_hold_due && beats_in > 200)
            begin
                long_hold_due = 0;
                hold_cnt = 400;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                hold_cnt = pick_gap();
                rsp_ch.ready <= (hold_cnt == 0);
            end
        end
    end

    initial
    begin
        int k;
        bit narrow;
        tbl_count = 0;
        errors = 0;
        beats_in = 0;
        gap_cnt = 0;
        hold_cnt = 0;
        long_hold_due = 1;
        idle_cycles = 0;
        req_taken = 0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_CLEAR;
        req_ch.buffer_index = '0;
        req_ch.first_step = '0;
        req_ch.last_step = '0;
        req_ch.byte_size = '0;
        rsp_ch.ready = 1'b0;
        rst_n = 1'b0;

        // directed: empty plan, absent read, field extremes, ties, skipped buffer
        push_cmd(OP_PLAN, 8'd0);
        push_cmd(OP_READ, 8'd0);
        push_cmd(OP_CLEAR, 8'd0);
        push_load(10'd0, 10'd1023, 32'hFFFF_FFFF);
        push_load(10'd1023, 10'd0, 32'd1);
        push_load(10'd5, 10'd6, 32'd0);
        push_load(10'd5, 10'd9, 32'd16);
        push_load(10'd5, 10'd5, 32'd8);
        push_load(10'd10, 10'd12, 32'd8);
        push_cmd(OP_PLAN, 8'd0);
        for (int i = 0; i < 7; i++)
            push_cmd(OP_READ, 8'(i));
        push_cmd(OP_READ, 8'd255);
        push_cmd(OP_PLAN, 8'd0);
        push_sync();
        push_cmd(OP_CLEAR, 8'd0);
        push_cmd(OP_READ, 8'd1);

        // table full: one load past capacity is dropped
        for (int i = 0; i < NBUF + 1; i++)
            push_load(10'($urandom), 10'($urandom),
                      ($urandom_range(0, 15) == 0) ? 32'($urandom_range(1, 64)) : 32'd0);
        push_cmd(OP_PLAN, 8'd0);
        push_cmd(OP_READ, 8'd255);
        push_cmd(OP_READ, 8'($urandom));
        push_cmd(OP_CLEAR, 8'd0);

        while (pending_q.size() < 1050)
        begin
            k = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            narrow = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                push_cmd(OP_CLEAR, 8'($urandom));
            for (int i = 0; i < k; i++)
            begin
                logic [31:0] s;
                case ($urandom_range(0, 7))
                    0: s = 32'd0;
                    1: s = $urandom;
                    2: s = 32'hFFFF_FFFF;
                    default: s = 32'($urandom_range(1, 8)) << $urandom_range(0, 6);
                endcase
                if (narrow)
                    push_load(10'($urandom_range(0, 15)), 10'($urandom_range(0, 15)), s);
                else
                    push_load(10'($urandom), 10'($urandom), s);
                if ($urandom_range(0, 19) == 0)
                    push_cmd(OP_READ, 8'($urandom));
            end
            push_cmd(OP_PLAN, 8'($urandom));
            if ($urandom_range(0, 9) == 0)
                push_cmd(OP_PLAN, 8'd0);
            for (int i = 0; i < k + 2; i++)
                push_cmd(OP_READ, ($urandom_range(0, 7) == 0) ?
                         8'($urandom) : 8'($urandom_range(0, k + 1)));
            if ($urandom_range(0, 7) == 0)
                push_sync();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() > 0 || req_ch.valid || answer_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && answer_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
